### rtl/core/minv3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minv3_pkg
// Shared types, widths and helpers of the 3x3 / 2x2 fixed-point matrix
// inverse core (adjugate over determinant).
// ----------------------------------------------------------------------------
package minv3_pkg;

	// number format of entries and results
	localparam int FRAC_BITS = 16;
	localparam int WORD_W    = 32;
	localparam int N_ENT     = 9;

	// cofactor: difference of two 32x32 products
	localparam int COF_W   = 2 * WORD_W + 1;
	localparam int SPLIT_W = 32;
	// row expansion term and determinant
	localparam int DET_W   = COF_W + SPLIT_W;
	localparam int DMAG_W  = DET_W - 1;
	localparam int NMAG_W  = COF_W - 1;

	// quotient scaling and determinant output shifts
	localparam int QUOT_BITS = WORD_W;
	localparam int QSH       = 2 * FRAC_BITS;
	localparam int DSH_3X3   = 2 * FRAC_BITS;
	localparam int DSH_2X2   = FRAC_BITS;
	localparam int DIVD_W    = NMAG_W + QSH;
	localparam int CMP_W     = (DIVD_W > DMAG_W + QUOT_BITS) ? DIVD_W : DMAG_W + QUOT_BITS;

	// configuration
	localparam int CFG_IDX_W = 1;
	localparam int THR_W     = 41;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THR  = 1'd1;
	localparam logic MODE_2X2 = 1'b0;
	localparam logic MODE_3X3 = 1'b1;
	localparam logic [THR_W-1:0] THR_RESET = 41'd28;

	typedef logic signed [COF_W-1:0] cof_t;

	// input word: one matrix, row-major
	typedef struct packed {
		logic signed [WORD_W-1:0] a11;
		logic signed [WORD_W-1:0] a12;
		logic signed [WORD_W-1:0] a13;
		logic signed [WORD_W-1:0] a21;
		logic signed [WORD_W-1:0] a22;
		logic signed [WORD_W-1:0] a23;
		logic signed [WORD_W-1:0] a31;
		logic signed [WORD_W-1:0] a32;
		logic signed [WORD_W-1:0] a33;
	} in_word_t;

	// output word: inverse, determinant, singular flag
	typedef struct packed {
		logic signed [WORD_W-1:0] r11;
		logic signed [WORD_W-1:0] r12;
		logic signed [WORD_W-1:0] r13;
		logic signed [WORD_W-1:0] r21;
		logic signed [WORD_W-1:0] r22;
		logic signed [WORD_W-1:0] r23;
		logic signed [WORD_W-1:0] r31;
		logic signed [WORD_W-1:0] r32;
		logic signed [WORD_W-1:0] r33;
		logic signed [WORD_W-1:0] determinant;
		logic                     singular;
	} out_word_t;

	// cofactor stage word
	typedef struct packed {
		cof_t [N_ENT-1:0] cof;
		in_word_t         mat;
	} cof_word_t;

	// determinant stage word: exact determinant and mode-selected numerators
	typedef struct packed {
		logic signed [DET_W-1:0] det;
		cof_t [N_ENT-1:0]        num;
	} det_word_t;

	// one divider lane
	typedef struct packed {
		logic [DMAG_W-1:0]    rem;
		logic [QUOT_BITS-1:0] quo;
		logic [QUOT_BITS-1:0] dlo;
		logic                 neg;
		logic                 ovf;
	} lane_t;

	// divider pipeline word
	typedef struct packed {
		lane_t [N_ENT-1:0]        lane;
		logic [DMAG_W-1:0]        dmag;
		logic signed [WORD_W-1:0] det_out;
		logic                     sing;
	} div_word_t;

	// apply sign to a magnitude, saturating to the 32-bit range
	function automatic logic [WORD_W-1:0] sat_q(input logic ovf, input logic [WORD_W-1:0] m,
			input logic neg);
		logic [WORD_W:0] lim;
		logic [WORD_W:0] v;
		logic [WORD_W:0] s;
		lim = {1'b0, neg, {(WORD_W-1){!neg}}};
		v   = (ovf || ({1'b0, m} > lim)) ? lim : {1'b0, m};
		s   = neg ? (~v + 1'b1) : v;
		return s[WORD_W-1:0];
	endfunction

endpackage

### rtl/core/matrix_inverse_3x3_adjugate_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_adjugate_core
// Fixed-point Q16.16 3x3 / 2x2 matrix inverse by adjugate over determinant.
// ----------------------------------------------------------------------------
// Usage:
//   matrix / matrix_valid / matrix_stall carry one matrix word per accept;
//   inverse / inverse_valid / inverse_stall carry the result word (nine
//   inverse entries, truncated determinant, singular flag).
//   cfg_we writes dimension_mode (index 0) or singular_threshold (index 1);
//   write only while no word is in flight.
// Pipeline: 41 register stages, the 32-stage restoring divider (one
//   quotient bit per stage) behind eight stages of capture, products,
//   cofactors, determinant and scaling, plus the output register.
//   Throughput: one word per cycle while inverse_stall does not hold a
//   waiting result.
// Reset: all valid bits clear, 3x3 mode, threshold 28.
// Stall: when inverse_stall holds a waiting result, the whole pipeline
//   freezes; the input stage still takes one word if it is empty, then
//   matrix_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3_adjugate_core import minv3_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [THR_W-1:0]     cfg_data,
	input  logic                 matrix_valid,
	output logic                 matrix_stall,
	input  in_word_t             matrix,
	output logic                 inverse_valid,
	input  logic                 inverse_stall,
	output out_word_t            inverse
);

	logic             mode_q;
	logic [THR_W-1:0] thr_q;
	logic             en, accept, s1_valid;
	logic             cof_valid, det_valid, scl_valid, div_valid;
	cof_word_t        cof_word;
	det_word_t        det_word;
	div_word_t        scl_word, div_word;
	logic             inv_v_q;
	out_word_t        inv_q;
	logic [WORD_W-1:0] r [N_ENT];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_3X3;
			thr_q  <= THR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MODE: mode_q <= cfg_data[0];
				CFG_THR:  thr_q  <= cfg_data;
				default:  ;
			endcase
		end
	end

	// pipeline advance: held only while a result waits on a stalled receiver
	assign en           = !(inv_v_q && inverse_stall);
	assign matrix_stall = s1_valid && !en;
	assign accept       = matrix_valid && !matrix_stall;

	minv3_cofactor u_cof (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.accept   (accept),
		.matrix   (matrix),
		.s1_valid (s1_valid),
		.valid    (cof_valid),
		.word     (cof_word)
	);

	minv3_det u_det (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.mode     (mode_q),
		.valid_in (cof_valid),
		.word_in  (cof_word),
		.valid    (det_valid),
		.word     (det_word)
	);

	minv3_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.mode     (mode_q),
		.thr      (thr_q),
		.valid_in (det_valid),
		.word_in  (det_word),
		.valid    (scl_valid),
		.word     (scl_word)
	);

	minv3_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_in (scl_valid),
		.word_in  (scl_word),
		.valid    (div_valid),
		.word     (div_word)
	);

	// sign and saturate quotients; singular words carry zero entries
	always_comb begin
		for (int i = 0; i < N_ENT; i++)
			r[i] = div_word.sing ? '0 :
				sat_q(div_word.lane[i].ovf, div_word.lane[i].quo, div_word.lane[i].neg);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			inv_v_q <= 1'b0;
		else if (en)
			inv_v_q <= div_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inv_q.r11         <= r[0];
			inv_q.r12         <= r[1];
			inv_q.r13         <= r[2];
			inv_q.r21         <= r[3];
			inv_q.r22         <= r[4];
			inv_q.r23         <= r[5];
			inv_q.r31         <= r[6];
			inv_q.r32         <= r[7];
			inv_q.r33         <= r[8];
			inv_q.determinant <= div_word.det_out;
			inv_q.singular    <= div_word.sing;
		end
	end

	assign inverse_valid = inv_v_q;
	assign inverse       = inv_q;

endmodule

### rtl/core/minv3_cofactor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minv3_cofactor
// Input capture (s1), eighteen 32x32 products (s2), nine cofactors (s3).
// ----------------------------------------------------------------------------
module minv3_cofactor import minv3_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      accept,
	input  in_word_t  matrix,
	output logic      s1_valid,
	output logic      valid,
	output cof_word_t word
);

	// minor product operands: cof[i] = a[PA]*a[PB] - a[PC]*a[PD]
	localparam int PA [N_ENT] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
	localparam int PB [N_ENT] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
	localparam int PC [N_ENT] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
	localparam int PD [N_ENT] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

	in_word_t                 mat_s1, mat_s2, mat_s3;
	logic                     v_s1, v_s2, v_s3;
	logic signed [WORD_W-1:0] av [N_ENT];
	logic signed [2*WORD_W-1:0] pp_s2 [N_ENT];
	logic signed [2*WORD_W-1:0] pn_s2 [N_ENT];
	cof_t                     cof_s3 [N_ENT];

	// valid chain; s1 also fills while the pipe is held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en || !v_s1)
				v_s1 <= accept;
			if (en) begin
				v_s2 <= v_s1;
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			mat_s1 <= matrix;
	end

	// entries as an array
	always_comb begin
		av[0] = mat_s1.a11;
		av[1] = mat_s1.a12;
		av[2] = mat_s1.a13;
		av[3] = mat_s1.a21;
		av[4] = mat_s1.a22;
		av[5] = mat_s1.a23;
		av[6] = mat_s1.a31;
		av[7] = mat_s1.a32;
		av[8] = mat_s1.a33;
	end

	// s2: products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N_ENT; i++) begin
				pp_s2[i] <= av[PA[i]] * av[PB[i]];
				pn_s2[i] <= av[PC[i]] * av[PD[i]];
			end
			mat_s2 <= mat_s1;
		end
	end

	// s3: cofactors
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N_ENT; i++)
				cof_s3[i] <= COF_W'(pp_s2[i]) - COF_W'(pn_s2[i]);
			mat_s3 <= mat_s2;
		end
	end

	always_comb begin
		word.mat = mat_s3;
		for (int i = 0; i < N_ENT; i++)
			word.cof[i] = cof_s3[i];
	end

	assign s1_valid = v_s1;
	assign valid    = v_s3;

endmodule

### rtl/core/minv3_det.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minv3_det
// Exact determinant (first-row expansion over the cofactors in 3x3 mode, the
// 2x2 cofactor in 2x2 mode) (s4..s6) and selection of the 2x2 or 3x3 numerators.
// ----------------------------------------------------------------------------
module minv3_det import minv3_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      mode,
	input  logic      valid_in,
	input  cof_word_t word_in,
	output logic      valid,
	output det_word_t word
);

	logic                     v_s4, v_s5, v_s6;
	logic signed [WORD_W-1:0] ra [3];
	cof_t                     rc [3];
	logic signed [COF_W-1:0]  plo_s4 [3];
	logic signed [COF_W-1:0]  phi_s4 [3];
	cof_t [N_ENT-1:0]         num_s4, num_s5, num_s6;
	cof_t                     det2_s4, det2_s5;
	logic signed [DET_W-1:0]  t_s5 [3];
	logic signed [DET_W-1:0]  det_s6;
	cof_t [N_ENT-1:0]         num2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s4 <= valid_in;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// first row and its cofactors
	always_comb begin
		ra[0] = word_in.mat.a11;
		ra[1] = word_in.mat.a12;
		ra[2] = word_in.mat.a13;
		rc[0] = word_in.cof[0];
		rc[1] = word_in.cof[3];
		rc[2] = word_in.cof[6];
	end

	// 2x2 numerators
	always_comb begin
		num2    = '0;
		num2[0] = COF_W'(word_in.mat.a22);
		num2[1] = -COF_W'(word_in.mat.a12);
		num2[3] = -COF_W'(word_in.mat.a21);
		num2[4] = COF_W'(word_in.mat.a11);
	end

	// s4: split partial products, entry times low and high cofactor halves
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				plo_s4[k] <= ra[k] * $signed({1'b0, rc[k][SPLIT_W-1:0]});
				phi_s4[k] <= ra[k] * $signed(rc[k][COF_W-1:SPLIT_W]);
			end
			num_s4  <= (mode == MODE_3X3) ? word_in.cof : num2;
			det2_s4 <= word_in.cof[8];
		end
	end

	// s5: recombine each row term
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++)
				t_s5[k] <= $signed({phi_s4[k], {SPLIT_W{1'b0}}}) +
					DET_W'(plo_s4[k]);
			num_s5  <= num_s4;
			det2_s5 <= det2_s4;
		end
	end

	// s6: determinant
	always_ff @(posedge clk) begin
		if (en) begin
			det_s6 <= (mode == MODE_3X3) ? (t_s5[0] + t_s5[1] + t_s5[2]) : DET_W'(det2_s5);
			num_s6 <= num_s5;
		end
	end

	assign valid    = v_s6;
	assign word.det = det_s6;
	assign word.num = num_s6;

endmodule

### rtl/core/minv3_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minv3_scale
// Magnitudes and signs (s7), then singular test, quotient overflow test,
// divider seed and saturated determinant output (s8).
// ----------------------------------------------------------------------------
module minv3_scale import minv3_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             mode,
	input  logic [THR_W-1:0] thr,
	input  logic             valid_in,
	input  det_word_t        word_in,
	output logic             valid,
	output div_word_t        word
);

	logic                 v_s7, v_s8;
	logic                 dneg_s7;
	logic [DMAG_W-1:0]    dmag_s7;
	logic [N_ENT-1:0]     neg_s7;
	logic [NMAG_W-1:0]    nmag_s7 [N_ENT];
	logic [DET_W-1:0]     dabs;
	logic [COF_W-1:0]     nabs [N_ENT];
	logic [CMP_W-1:0]     dvd, dsr, dvd_hi;
	logic [DMAG_W-1:0]    dsh;
	div_word_t            nxt, w_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s7 <= valid_in;
			v_s8 <= v_s7;
		end
	end

	// absolute values
	always_comb begin
		dabs = word_in.det[DET_W-1] ? DET_W'(-word_in.det) : DET_W'(word_in.det);
		for (int i = 0; i < N_ENT; i++)
			nabs[i] = word_in.num[i][COF_W-1] ? COF_W'(-word_in.num[i]) :
				COF_W'(word_in.num[i]);
	end

	// s7: magnitudes and signs
	always_ff @(posedge clk) begin
		if (en) begin
			dneg_s7 <= word_in.det[DET_W-1];
			dmag_s7 <= dabs[DMAG_W-1:0];
			for (int i = 0; i < N_ENT; i++) begin
				nmag_s7[i] <= nabs[i][NMAG_W-1:0];
				neg_s7[i]  <= word_in.num[i][COF_W-1] ^ word_in.det[DET_W-1];
			end
		end
	end

	// s8 logic: per lane, quotient fits 32 bits unless |num|<<QSH >= |det|<<32
	always_comb begin
		nxt      = '0;
		dsr      = CMP_W'(dmag_s7) << QUOT_BITS;
		dvd      = '0;
		dvd_hi   = '0;
		for (int i = 0; i < N_ENT; i++) begin
			dvd    = CMP_W'(nmag_s7[i]) << QSH;
			dvd_hi = dvd >> QUOT_BITS;
			nxt.lane[i].ovf = (dvd >= dsr);
			nxt.lane[i].rem = dvd_hi[DMAG_W-1:0];
			nxt.lane[i].dlo = dvd[QUOT_BITS-1:0];
			nxt.lane[i].quo = '0;
			nxt.lane[i].neg = neg_s7[i];
		end
		nxt.dmag = dmag_s7;
		nxt.sing = (dmag_s7 <= DMAG_W'(thr));
		dsh      = (mode == MODE_3X3) ? (dmag_s7 >> DSH_3X3) : (dmag_s7 >> DSH_2X2);
		nxt.det_out = sat_q(|dsh[DMAG_W-1:WORD_W], dsh[WORD_W-1:0], dneg_s7);
	end

	always_ff @(posedge clk) begin
		if (en)
			w_s8 <= nxt;
	end

	assign valid = v_s8;
	assign word  = w_s8;

endmodule

### rtl/core/minv3_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minv3_divider
// Nine-lane restoring divider, one quotient bit per pipeline stage, sharing
// the determinant magnitude as divisor.
// ----------------------------------------------------------------------------
module minv3_divider import minv3_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      valid_in,
	input  div_word_t word_in,
	output logic      valid,
	output div_word_t word
);

	// one restoring step on every lane
	function automatic div_word_t div_step(input div_word_t w);
		div_word_t       r;
		logic [DMAG_W:0] r2;
		logic [DMAG_W:0] diff;
		r = w;
		for (int i = 0; i < N_ENT; i++) begin
			r2   = {w.lane[i].rem, w.lane[i].dlo[QUOT_BITS-1]};
			diff = r2 - {1'b0, w.dmag};
			r.lane[i].rem = diff[DMAG_W] ? r2[DMAG_W-1:0] : diff[DMAG_W-1:0];
			r.lane[i].quo = {w.lane[i].quo[QUOT_BITS-2:0], !diff[DMAG_W]};
			r.lane[i].dlo = {w.lane[i].dlo[QUOT_BITS-2:0], 1'b0};
		end
		return r;
	endfunction

	logic [QUOT_BITS-1:0] v_s;
	div_word_t            w_s [QUOT_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s <= '0;
		else if (en)
			v_s <= {v_s[QUOT_BITS-2:0], valid_in};
	end

	// stage registers
	for (genvar g = 0; g < QUOT_BITS; g++) begin : g_stage
		if (g == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en)
					w_s[g] <= div_step(word_in);
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en)
					w_s[g] <= div_step(w_s[g-1]);
			end
		end
	end

	assign valid = v_s[QUOT_BITS-1];
	assign word  = w_s[QUOT_BITS-1];

endmodule

### rtl/core/minv3_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minv3_checker
// Port-level checks of the matrix inverse core, bound to the top level.
// ----------------------------------------------------------------------------
module minv3_checker import minv3_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [THR_W-1:0]     cfg_data,
	input logic                 matrix_valid,
	input logic                 matrix_stall,
	input in_word_t             matrix,
	input logic                 inverse_valid,
	input logic                 inverse_stall,
	input out_word_t            inverse
);

	logic mode_q;

	// shadow of the dimension mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_q <= MODE_3X3;
		else if (cfg_we && cfg_index == CFG_MODE)
			mode_q <= cfg_data[0];
	end

	// a stalled result word stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		inverse_valid && inverse_stall |=> inverse_valid)
		else $error("result word dropped under stall");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		inverse_valid && inverse_stall |=> $stable(inverse))
		else $error("stalled result word changed");

	// singular words carry zero entries
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		inverse_valid && inverse.singular |->
			inverse.r11 == '0 && inverse.r12 == '0 && inverse.r13 == '0 &&
			inverse.r21 == '0 && inverse.r22 == '0 && inverse.r23 == '0 &&
			inverse.r31 == '0 && inverse.r32 == '0 && inverse.r33 == '0)
		else $error("singular word with nonzero entries");

	// 2x2 mode leaves the third row and column zero
	a_2x2_zero: assert property (@(posedge clk) disable iff (!arst_n)
		inverse_valid && mode_q == MODE_2X2 |->
			inverse.r13 == '0 && inverse.r23 == '0 && inverse.r31 == '0 &&
			inverse.r32 == '0 && inverse.r33 == '0)
		else $error("2x2 word with nonzero outer entries");

	// input is only held back by a waiting result
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		!inverse_valid |-> !matrix_stall)
		else $error("input stalled with no result waiting");

endmodule

bind matrix_inverse_3x3_adjugate_core minv3_checker u_minv3_checker (.*);
